FILE: hw/rtl/priority_round_robin_scheduler_core_assert.svh
// assertion macros for the scheduler core checker
// no dependencies; include guard keeps a second include harmless
`ifndef PRIORITY_ROUND_ROBIN_SCHEDULER_CORE_ASSERT_SVH
`define PRIORITY_ROUND_ROBIN_SCHEDULER_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define PRRS_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define PRRS_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/prrs_pkg.sv
// shared types, codes and constants of the priority round-robin scheduler
// no dependencies
package prrs_pkg;

  localparam int ENTRIES_DEFAULT = 64;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // status codes held in the status table
  localparam logic [2:0] ST_FREE     = 3'd0;
  localparam logic [2:0] ST_RUNNABLE = 3'd1;
  localparam logic [2:0] ST_RUNNING  = 3'd2;
  localparam logic [2:0] ST_DYING    = 3'd3;

  localparam logic [3:0] PRIO_RESET = 4'hF;

  localparam logic        MODE_RESET     = 1'b1;
  localparam logic [3:0]  MIN_PRIO_RESET = 4'd0;
  localparam logic [3:0]  MAX_PRIO_RESET = 4'd15;
  localparam logic [15:0] BOOST_RESET    = 16'd64;

  typedef enum logic [1:0] {
    CFG_SCHED_MODE = 2'd0,
    CFG_MIN_PRIO   = 2'd1,
    CFG_MAX_PRIO   = 2'd2,
    CFG_BOOST_IVL  = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_YIELD  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    OUT_SWITCHED   = 2'd0,
    OUT_KEPT       = 2'd1,
    OUT_IDLE       = 2'd2,
    OUT_NONE_ALIVE = 2'd3
  } outcome_e;

  typedef struct packed {
    op_e        operation;
    logic [5:0] entry;
    logic [2:0] new_status;
  } in_t;

  typedef struct packed {
    outcome_e   outcome;
    logic [5:0] chosen_entry;
    logic [3:0] chosen_priority;
  } out_t;

  // datapath commands issued by the controller
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_UPDATE,
    CMD_READ_CUR,
    CMD_DECAY,
    CMD_BOOST,
    CMD_SCAN,
    CMD_DECIDE,
    CMD_DEMOTE,
    CMD_FINISH
  } dp_cmd_e;

  typedef struct packed {
    logic sweep_last;
    logic boost_due;
    logic scan_done;
    logic out_free;
  } dp_sts_t;

endpackage

FILE: hw/rtl/prrs_dp.sv
// scheduler datapath: status and priority tables, scan registers, config and result word
// depends on prrs_pkg; driven by prrs_ctrl commands
module prrs_dp #(
  parameter int ENTRIES = prrs_pkg::ENTRIES_DEFAULT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  prrs_pkg::dp_cmd_e                cmd_i,
  output prrs_pkg::dp_sts_t                sts_o,
  input  prrs_pkg::in_t                    in_word_i,
  input  logic                             cfg_we_i,
  input  logic [prrs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [prrs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output prrs_pkg::out_t                   out_word_o
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ENTRIES - 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(ENTRIES);

  logic [2:0] status_mem [ENTRIES];
  logic [3:0] prio_mem   [ENTRIES];

  // configuration
  logic        mode_q;
  logic [3:0]  min_prio_q, max_prio_q;
  logic [15:0] boost_ivl_q;

  // scheduler state
  logic [IDX_W-1:0] cur_idx_q;
  logic             cur_valid_q;
  logic [15:0]      phase_q;
  logic             yielded_q;

  // per-yield working registers
  logic [CNT_W-1:0] cnt_q;
  logic [IDX_W-1:0] addr_q, eval_idx_q;
  logic             eval_q;
  logic [2:0]       st_rdata_q, cur_st_q;
  logic [3:0]       pr_rdata_q, cur_pr_q, best_pr_q;
  logic [IDX_W-1:0] best_q;
  logic             found_q, done_q, alive_q;

  prrs_pkg::out_t out_q;
  logic           out_valid_q;

  logic [IDX_W-1:0] rd_addr, addr_next, start_idx;
  logic             st_we, pr_we;
  logic [IDX_W-1:0] st_waddr, pr_waddr;
  logic [2:0]       st_wdata;
  logic [3:0]       pr_wdata, decayed;
  logic             in_range, cur_running, keep_cur, issue, out_free;
  logic             take, stop;
  logic [16:0]      phase_inc;
  logic [15:0]      ivl_eff, phase_next;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign cur_running = cur_valid_q && (cur_st_q == prrs_pkg::ST_RUNNING);
  assign in_range    = {26'd0, in_word_i.entry} < 32'(ENTRIES);
  assign decayed     = (pr_rdata_q > min_prio_q) ? pr_rdata_q - 4'd1 : min_prio_q;
  assign addr_next   = (addr_q == IDX_LAST) ? '0 : addr_q + IDX_W'(1);
  assign issue       = (cmd_i == prrs_pkg::CMD_SCAN) && (cnt_q != CNT_END);
  assign rd_addr     = (cmd_i == prrs_pkg::CMD_SCAN) ? addr_q : cur_idx_q;

  // round robin starts after the current entry, priority mode at it
  always_comb begin
    if (!cur_valid_q) begin
      start_idx = '0;
    end else if (!mode_q) begin
      start_idx = (cur_idx_q == IDX_LAST) ? '0 : cur_idx_q + IDX_W'(1);
    end else begin
      start_idx = cur_idx_q;
    end
  end

  assign ivl_eff    = (boost_ivl_q == 16'd0) ? 16'd1 : boost_ivl_q;
  assign phase_inc  = {1'b0, phase_q} + 17'd1;
  assign phase_next = (phase_inc >= {1'b0, ivl_eff}) ? 16'd0 : phase_inc[15:0];

  // scan evaluation of the entry read last cycle
  always_comb begin
    take = 1'b0;
    stop = 1'b0;
    if (eval_q && !done_q && st_rdata_q == prrs_pkg::ST_RUNNABLE) begin
      if (!mode_q) begin
        take = 1'b1;
        stop = 1'b1;
      end else if (!found_q || pr_rdata_q > best_pr_q) begin
        take = 1'b1;
        stop = (pr_rdata_q == max_prio_q);
      end
    end
  end

  assign keep_cur = cur_running && (!found_q || (mode_q && cur_pr_q > best_pr_q));

  // table write port selection
  always_comb begin
    st_we    = 1'b0;
    st_waddr = cur_idx_q;
    st_wdata = prrs_pkg::ST_FREE;
    pr_we    = 1'b0;
    pr_waddr = cnt_q[IDX_W-1:0];
    pr_wdata = max_prio_q;
    case (cmd_i)
      prrs_pkg::CMD_CLEAR: begin
        st_we    = 1'b1;
        st_waddr = cnt_q[IDX_W-1:0];
        pr_we    = 1'b1;
        pr_wdata = prrs_pkg::PRIO_RESET;
      end
      prrs_pkg::CMD_UPDATE: begin
        st_we    = in_range;
        st_waddr = IDX_W'(in_word_i.entry);
        st_wdata = in_word_i.new_status;
      end
      prrs_pkg::CMD_DECAY: begin
        pr_we    = mode_q && cur_valid_q;
        pr_waddr = cur_idx_q;
        pr_wdata = decayed;
      end
      prrs_pkg::CMD_BOOST: begin
        pr_we = 1'b1;
      end
      prrs_pkg::CMD_DEMOTE: begin
        st_we    = found_q && cur_running;
        st_wdata = prrs_pkg::ST_RUNNABLE;
      end
      prrs_pkg::CMD_FINISH: begin
        st_we    = found_q;
        st_waddr = best_q;
        st_wdata = prrs_pkg::ST_RUNNING;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      status_mem[st_waddr] <= st_wdata;
    end
    if (pr_we) begin
      prio_mem[pr_waddr] <= pr_wdata;
    end
    st_rdata_q <= status_mem[rd_addr];
    pr_rdata_q <= prio_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= prrs_pkg::MODE_RESET;
      min_prio_q  <= prrs_pkg::MIN_PRIO_RESET;
      max_prio_q  <= prrs_pkg::MAX_PRIO_RESET;
      boost_ivl_q <= prrs_pkg::BOOST_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        prrs_pkg::CFG_SCHED_MODE: mode_q      <= cfg_data_i[0];
        prrs_pkg::CFG_MIN_PRIO:   min_prio_q  <= cfg_data_i[3:0];
        prrs_pkg::CFG_MAX_PRIO:   max_prio_q  <= cfg_data_i[3:0];
        prrs_pkg::CFG_BOOST_IVL:  boost_ivl_q <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_idx_q   <= '0;
      cur_valid_q <= 1'b0;
      phase_q     <= '0;
      yielded_q   <= 1'b0;
      cnt_q       <= '0;
      addr_q      <= '0;
      eval_q      <= 1'b0;
      found_q     <= 1'b0;
      done_q      <= 1'b0;
      alive_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      eval_q <= issue;
      if (cmd_i == prrs_pkg::CMD_FINISH) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (eval_q) begin
        alive_q <= alive_q || (st_rdata_q == prrs_pkg::ST_RUNNABLE)
                           || (st_rdata_q == prrs_pkg::ST_RUNNING)
                           || (st_rdata_q == prrs_pkg::ST_DYING);
      end
      if (take) begin
        found_q <= 1'b1;
      end
      if (stop) begin
        done_q <= 1'b1;
      end
      case (cmd_i)
        prrs_pkg::CMD_CLEAR, prrs_pkg::CMD_BOOST: begin
          cnt_q <= (cnt_q == CNT_LAST) ? '0 : cnt_q + CNT_W'(1);
        end
        prrs_pkg::CMD_DECAY: begin
          cnt_q     <= '0;
          addr_q    <= start_idx;
          found_q   <= 1'b0;
          done_q    <= 1'b0;
          alive_q   <= 1'b0;
          phase_q   <= phase_next;
          yielded_q <= 1'b1;
        end
        prrs_pkg::CMD_SCAN: begin
          if (issue) begin
            cnt_q  <= cnt_q + CNT_W'(1);
            addr_q <= addr_next;
          end
        end
        prrs_pkg::CMD_DECIDE: begin
          found_q <= found_q || keep_cur;
        end
        prrs_pkg::CMD_FINISH: begin
          cur_valid_q <= found_q;
          cur_idx_q   <= found_q ? best_q : '0;
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (issue) begin
      eval_idx_q <= addr_q;
    end
    if (take) begin
      best_q    <= eval_idx_q;
      best_pr_q <= pr_rdata_q;
    end
    case (cmd_i)
      prrs_pkg::CMD_DECAY: begin
        cur_st_q <= st_rdata_q;
        if (!mode_q) begin
          cur_pr_q <= pr_rdata_q;
        end else if (yielded_q && phase_q == 16'd0) begin
          cur_pr_q <= max_prio_q;
        end else begin
          cur_pr_q <= decayed;
        end
      end
      prrs_pkg::CMD_DECIDE: begin
        if (keep_cur) begin
          best_q    <= cur_idx_q;
          best_pr_q <= cur_pr_q;
        end
      end
      prrs_pkg::CMD_FINISH: begin
        if (found_q) begin
          out_q.outcome         <= (cur_valid_q && best_q == cur_idx_q) ?
                                   prrs_pkg::OUT_KEPT : prrs_pkg::OUT_SWITCHED;
          out_q.chosen_entry    <= 6'(best_q);
          out_q.chosen_priority <= best_pr_q;
        end else begin
          out_q.outcome         <= alive_q ? prrs_pkg::OUT_IDLE : prrs_pkg::OUT_NONE_ALIVE;
          out_q.chosen_entry    <= 6'd0;
          out_q.chosen_priority <= 4'd0;
        end
      end
      default: begin
      end
    endcase
  end

  assign sts_o.sweep_last = (cnt_q == CNT_LAST);
  assign sts_o.boost_due  = mode_q && yielded_q && (phase_q == 16'd0);
  assign sts_o.scan_done  = (cnt_q == CNT_END) && !eval_q;
  assign sts_o.out_free   = out_free;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

FILE: hw/rtl/prrs_ctrl.sv
// scheduler controller: sequences clearing, yield phases and result hand-off
// depends on prrs_pkg; commands prrs_dp
module prrs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  prrs_pkg::op_e     in_op_i,
  input  prrs_pkg::dp_sts_t sts_i,
  output prrs_pkg::dp_cmd_e cmd_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECAY,
    S_BOOST,
    S_SCAN,
    S_DECIDE,
    S_DEMOTE,
    S_FINISH
  } state_e;

  state_e state_q;
  logic   in_acc;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    cmd_o = prrs_pkg::CMD_NONE;
    case (state_q)
      S_CLEAR:  cmd_o = prrs_pkg::CMD_CLEAR;
      S_IDLE: begin
        if (in_acc) begin
          cmd_o = (in_op_i == prrs_pkg::OP_YIELD) ? prrs_pkg::CMD_READ_CUR
                                                  : prrs_pkg::CMD_UPDATE;
        end
      end
      S_DECAY:  cmd_o = prrs_pkg::CMD_DECAY;
      S_BOOST:  cmd_o = prrs_pkg::CMD_BOOST;
      S_SCAN:   cmd_o = prrs_pkg::CMD_SCAN;
      S_DECIDE: cmd_o = prrs_pkg::CMD_DECIDE;
      S_DEMOTE: cmd_o = prrs_pkg::CMD_DEMOTE;
      S_FINISH: cmd_o = sts_i.out_free ? prrs_pkg::CMD_FINISH : prrs_pkg::CMD_NONE;
      default:  cmd_o = prrs_pkg::CMD_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      case (state_q)
        S_CLEAR: begin
          if (sts_i.sweep_last) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc && in_op_i == prrs_pkg::OP_YIELD) begin
            state_q <= S_DECAY;
          end
        end
        S_DECAY:  state_q <= sts_i.boost_due ? S_BOOST : S_SCAN;
        S_BOOST: begin
          if (sts_i.sweep_last) begin
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (sts_i.scan_done) begin
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: state_q <= S_DEMOTE;
        S_DEMOTE: state_q <= S_FINISH;
        S_FINISH: begin
          if (sts_i.out_free) begin
            state_q <= S_IDLE;
          end
        end
        default:  state_q <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/priority_round_robin_scheduler_core.sv
// Task scheduler over ENTRIES table entries, each with a status and a priority.
// An update word writes one entry's status. A yield word reads the current entry,
// decays its priority in priority mode, then scans the whole table one entry per
// cycle through the table read port, preceded by a global priority boost when one
// falls due (the boost rewrites every priority one per cycle). The result register
// frees the input side once loaded. After reset a clearing pass over all ENTRIES
// entries initialises both tables; no word is accepted until it ends, while
// configuration writes are taken at any time. Configuration is to be written only
// while idle; the user must keep to this, the block itself does not enforce it.
// depends on prrs_pkg, prrs_ctrl and prrs_dp
module priority_round_robin_scheduler_core #(
  parameter int ENTRIES = prrs_pkg::ENTRIES_DEFAULT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  prrs_pkg::in_t                    in_word_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output prrs_pkg::out_t                   out_word_o,
  input  logic                             cfg_we_i,
  input  logic [prrs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [prrs_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  prrs_pkg::dp_cmd_e cmd;
  prrs_pkg::dp_sts_t sts;

  prrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_op_i    (in_word_i.operation),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  prrs_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_word_i   (in_word_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

FILE: hw/rtl/prrs_chk.sv
// port-level checker for the scheduler core, bound to the top level
// depends on prrs_pkg and the assertion macro header
`include "priority_round_robin_scheduler_core_assert.svh"

module prrs_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input prrs_pkg::in_t                   in_word_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input prrs_pkg::out_t                  out_word_o,
  input logic                            cfg_we_i,
  input logic [prrs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [prrs_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  `PRRS_ASSERT_NXT(a_out_valid_held, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "result word dropped while stalled")
  `PRRS_ASSERT_NXT(a_out_word_held, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_word_o), "result word changed while stalled")
  // a halt reports no entry and no priority
  `PRRS_ASSERT_IMP(a_halt_zero, clk_i, rst_ni, out_valid_o && (out_word_o.outcome == prrs_pkg::OUT_IDLE || out_word_o.outcome == prrs_pkg::OUT_NONE_ALIVE), out_word_o.chosen_entry == 6'd0 && out_word_o.chosen_priority == 4'd0, "halt result carries an entry")
  // no word yields a result in the very next cycle
  `PRRS_ASSERT_NXT(a_no_instant_result, clk_i, rst_ni, in_valid_i && !in_stall_o, !$rose(out_valid_o), "result too soon after accepted word")

endmodule

bind priority_round_robin_scheduler_core prrs_chk u_prrs_chk (.*);
